// File: src/kit_pkg.sv
// ---------------------------------------------------------------------------
// kit_pkg: shared types and constants of the keyed index table
// Record and table-entry layouts, operation codes and a saturating
// increment used by the sequencer and its helper modules.
// ---------------------------------------------------------------------------
`default_nettype none

package kit_pkg;

  // Default table depth
  localparam int KIT_ENTRIES = 64;

  // Field widths
  localparam int KEY_W  = 64;
  localparam int ADDR_W = 32;
  localparam int SIZE_W = 16;
  localparam int HIT_W  = 8;
  localparam int CNT_W  = 32;
  localparam int MODE_W = 3;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_LOOKUP       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PEEK         = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INSERT       = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REPLACE_MTCH = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REMOVE       = 3'd4;
  localparam logic [MODE_W-1:0] MODE_REMOVE_MTCH  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SET_HITS     = 3'd6;
  localparam logic [MODE_W-1:0] MODE_CLEAR        = 3'd7;

  // Record carried by each entry
  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] size;
    logic [HIT_W-1:0]  total_hits;
    logic [HIT_W-1:0]  current_hits;
  } rec_t;

  // One table word: valid flag, key and record
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    rec_t             rec;
  } entry_t;

  // Saturating 8-bit increment
  function automatic logic [HIT_W-1:0] sat_inc8(input logic [HIT_W-1:0] v);
    logic [HIT_W-1:0] r;
    r = (v == '1) ? v : v + HIT_W'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/kit_mem.sv
// ---------------------------------------------------------------------------
// kit_mem: table storage
// Memory with a write port and a registered read port, one entry word per slot.
// ---------------------------------------------------------------------------
`default_nettype none

module kit_mem #(
  parameter int TABLE_ENTRIES = kit_pkg::KIT_ENTRIES
) (
  input  wire                                    clk,
  input  wire                                    wr_en,
  input  wire  [$clog2(TABLE_ENTRIES)-1:0]       wr_addr,
  input  wire  kit_pkg::entry_t                  wr_data,
  input  wire                                    rd_en,
  input  wire  [$clog2(TABLE_ENTRIES)-1:0]       rd_addr,
  output kit_pkg::entry_t                        rd_data
);
  import kit_pkg::*;

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: src/kit_scan.sv
// ---------------------------------------------------------------------------
// kit_scan: shared key comparator
// Compares one table word per cycle with the request key and keeps the
// first matching slot with its record and the first free slot.
// ---------------------------------------------------------------------------
`default_nettype none

module kit_scan #(
  parameter int TABLE_ENTRIES = kit_pkg::KIT_ENTRIES
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  input  wire                                word_vld,
  input  wire  [$clog2(TABLE_ENTRIES)-1:0]   word_idx,
  input  wire  kit_pkg::entry_t              word,
  input  wire  [kit_pkg::KEY_W-1:0]          key,
  output logic                               hit,
  output logic [$clog2(TABLE_ENTRIES)-1:0]   hit_idx,
  output kit_pkg::rec_t                      hit_rec,
  output logic                               free_vld,
  output logic [$clog2(TABLE_ENTRIES)-1:0]   free_idx
);
  import kit_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  rec_t             hit_rec_r;
  logic             free_vld_r;
  logic [IDX_W-1:0] free_idx_r;
  logic             key_eq;

  assign key_eq = word.valid && (word.key == key);

  // Track first hit and first free slot over the sweep
  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      hit_r      <= 1'b0;
      free_vld_r <= 1'b0;
    end else if (word_vld) begin
      if (key_eq && !hit_r) begin
        hit_r <= 1'b1;
      end
      if (!word.valid && !free_vld_r) begin
        free_vld_r <= 1'b1;
      end
    end
  end

  // Capture slot indexes and record
  always_ff @(posedge clk) begin
    if (word_vld && key_eq && !hit_r) begin
      hit_idx_r <= word_idx;
      hit_rec_r <= word.rec;
    end
    if (word_vld && !word.valid && !free_vld_r) begin
      free_idx_r <= word_idx;
    end
  end

  assign hit      = hit_r;
  assign hit_idx  = hit_idx_r;
  assign hit_rec  = hit_rec_r;
  assign free_vld = free_vld_r;
  assign free_idx = free_idx_r;

endmodule

`default_nettype wire

// File: src/keyed_index_table_with_hit_counts_unit.sv
// ---------------------------------------------------------------------------
// keyed_index_table_with_hit_counts_unit: keyed index table
// Maps 64-bit keys to address/size records with hit counters. A sequencer
// sweeps all slots through one comparator then applies one update, or wipes them.
// ---------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  in_     | input     | in_valid/in_stall   | mode, key, addresses, size, hits
//  out_    | output    | out_valid/out_stall | found, matched, full, record, count
//
//  An accepted request passes the states scan (one table read per slot
//  through the single memory read port), drain (last compare), update
//  (table write) and emit (output load) before its result is ready.
//  A clear request wipes one slot write per cycle, then loads the output.
//  After reset a clearing pass over all TABLE_ENTRIES slots runs before the
//  first request is taken. A stalled result holds in the output register;
//  the next request can be accepted while it waits.
// ---------------------------------------------------------------------------
`default_nettype none

module keyed_index_table_with_hit_counts_unit #(
  parameter int TABLE_ENTRIES = kit_pkg::KIT_ENTRIES
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  [kit_pkg::MODE_W-1:0]      in_mode,
  input  wire  [kit_pkg::KEY_W-1:0]       in_key,
  input  wire  [kit_pkg::ADDR_W-1:0]      in_entry_address,
  input  wire  [kit_pkg::ADDR_W-1:0]      in_expected_address,
  input  wire  [kit_pkg::SIZE_W-1:0]      in_size_estimate,
  input  wire  [kit_pkg::HIT_W-1:0]       in_new_current_hits,
  input  wire  [kit_pkg::HIT_W-1:0]       in_new_total_hits,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic                            out_found,
  output logic                            out_matched,
  output logic                            out_table_full,
  output logic [kit_pkg::ADDR_W-1:0]      out_record_address,
  output logic [kit_pkg::SIZE_W-1:0]      out_record_size,
  output logic [kit_pkg::HIT_W-1:0]       out_record_total_hits,
  output logic [kit_pkg::HIT_W-1:0]       out_record_current_hits,
  output logic [kit_pkg::CNT_W-1:0]       out_unaccessed_removals
);
  import kit_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

  // Sequencer states
  localparam logic [2:0] ST_WIPE   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_UPDATE = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  logic [2:0]       state_r;
  logic [2:0]       state_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic             wipe_op_r;
  logic             wipe_op_nxt;
  logic             cmp_vld_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             res_matched_r;
  logic             res_matched_nxt;
  logic             res_full_r;
  logic             res_full_nxt;

  // Latched request
  logic [MODE_W-1:0] req_mode_r;
  logic [KEY_W-1:0]  req_key_r;
  logic [ADDR_W-1:0] req_addr_r;
  logic [ADDR_W-1:0] req_expect_r;
  logic [SIZE_W-1:0] req_size_r;
  logic [HIT_W-1:0]  req_cur_r;
  logic [HIT_W-1:0]  req_tot_r;

  // Output register
  logic              out_valid_r;
  logic              out_found_r;
  logic              out_matched_r;
  logic              out_full_r;
  rec_t              out_rec_r;
  logic [CNT_W-1:0]  out_cnt_r;

  logic              accept;
  logic              start;
  logic              out_load;

  // Memory port
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  logic              rd_en;
  entry_t            rd_data;

  // Comparator results
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  rec_t              hit_rec;
  logic              free_vld;
  logic [IDX_W-1:0]  free_idx;
  rec_t              found_rec;
  logic              addr_match;
  logic              note;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign start    = accept;
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  kit_mem #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  kit_scan #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .word_vld (cmp_vld_r),
    .word_idx (cmp_idx_r),
    .word     (rd_data),
    .key      (req_key_r),
    .hit      (hit),
    .hit_idx  (hit_idx),
    .hit_rec  (hit_rec),
    .free_vld (free_vld),
    .free_idx (free_idx)
  );

  assign found_rec  = hit ? hit_rec : '0;
  assign addr_match = hit && (hit_rec.address == req_expect_r);

  // Sequencer, memory access and update decode
  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    wipe_op_nxt     = wipe_op_r;
    cnt_nxt         = cnt_r;
    res_matched_nxt = res_matched_r;
    res_full_nxt    = res_full_r;
    rd_en           = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = hit_idx;
    wr_data         = '{valid: 1'b1, key: req_key_r, rec: hit_rec};
    note            = 1'b0;

    unique case (state_r)
      ST_WIPE: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = '0;
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r == IDX_LAST) begin
          idx_nxt   = '0;
          state_nxt = wipe_op_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          idx_nxt         = '0;
          res_matched_nxt = 1'b0;
          res_full_nxt    = 1'b0;
          if (in_mode == MODE_CLEAR) begin
            wipe_op_nxt = 1'b1;
            cnt_nxt     = '0;
            state_nxt   = ST_WIPE;
          end else begin
            wipe_op_nxt = 1'b0;
            state_nxt   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_en   = 1'b1;
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r == IDX_LAST) begin
          idx_nxt   = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_nxt = ST_EMIT;
        case (req_mode_r)
          MODE_LOOKUP: begin
            wr_en                        = hit;
            wr_data.rec.total_hits       = sat_inc8(hit_rec.total_hits);
            wr_data.rec.current_hits     = sat_inc8(hit_rec.current_hits);
          end
          MODE_INSERT: begin
            wr_data.rec.address      = req_addr_r;
            wr_data.rec.size         = req_size_r;
            wr_data.rec.total_hits   = '0;
            wr_data.rec.current_hits = '0;
            if (hit) begin
              wr_en = 1'b1;
              note  = 1'b1;
            end else if (free_vld) begin
              wr_en   = 1'b1;
              wr_addr = free_idx;
            end else begin
              res_full_nxt = 1'b1;
            end
          end
          MODE_REPLACE_MTCH: begin
            wr_en                    = addr_match;
            res_matched_nxt          = addr_match;
            wr_data.rec.address      = req_addr_r;
            wr_data.rec.current_hits = '0;
          end
          MODE_REMOVE: begin
            wr_en         = hit;
            note          = hit;
            wr_data.valid = 1'b0;
          end
          MODE_REMOVE_MTCH: begin
            wr_en           = addr_match;
            note            = addr_match;
            res_matched_nxt = addr_match;
            wr_data.valid   = 1'b0;
          end
          MODE_SET_HITS: begin
            wr_en                    = hit;
            wr_data.rec.total_hits   = req_tot_r;
            wr_data.rec.current_hits = req_cur_r;
          end
          default: begin
          end
        endcase
        // Count removal, or overwrite by an insert, of an entry that was never hit
        if (note && (hit_rec.total_hits == '0) && (cnt_r != '1)) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_WIPE;
      idx_r         <= '0;
      wipe_op_r     <= 1'b0;
      cmp_vld_r     <= 1'b0;
      cnt_r         <= '0;
      res_matched_r <= 1'b0;
      res_full_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      idx_r         <= idx_nxt;
      wipe_op_r     <= wipe_op_nxt;
      cmp_vld_r     <= rd_en;
      cnt_r         <= cnt_nxt;
      res_matched_r <= res_matched_nxt;
      res_full_r    <= res_full_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold request fields and compare index
  always_ff @(posedge clk) begin
    cmp_idx_r <= idx_r;
    if (accept) begin
      req_mode_r   <= in_mode;
      req_key_r    <= in_key;
      req_addr_r   <= in_entry_address;
      req_expect_r <= in_expected_address;
      req_size_r   <= in_size_estimate;
      req_cur_r    <= in_new_current_hits;
      req_tot_r    <= in_new_total_hits;
    end
  end

  // Load result into the output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r   <= hit;
      out_matched_r <= res_matched_r;
      out_full_r    <= res_full_r;
      out_rec_r     <= found_rec;
      out_cnt_r     <= cnt_r;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_found               = out_found_r;
  assign out_matched             = out_matched_r;
  assign out_table_full          = out_full_r;
  assign out_record_address      = out_rec_r.address;
  assign out_record_size         = out_rec_r.size;
  assign out_record_total_hits   = out_rec_r.total_hits;
  assign out_record_current_hits = out_rec_r.current_hits;
  assign out_unaccessed_removals = out_cnt_r;

endmodule

`default_nettype wire
